@@ hdl/smtp_reply_code_parser_core_assert.svh @@
// Assertion macros shared by the SMTP reply-code parser modules.
`ifndef SMTP_REPLY_CODE_PARSER_CORE_ASSERT_SVH
`define SMTP_REPLY_CODE_PARSER_CORE_ASSERT_SVH

// Check a property on every clock edge outside reset.
`define SRCP_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check that a condition in one cycle implies a consequence in the next cycle.
`define SRCP_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ hdl/smtp_rcp_pkg.sv @@
// Types, constants and codes shared by the SMTP reply-code parser.
package smtp_rcp_pkg;

  localparam int MAX_LINE_BYTES = 4096;
  localparam int LB_W           = $clog2(MAX_LINE_BYTES);
  localparam int CODE_W         = 10;
  localparam int STATUS_W       = 3;
  localparam int CODE_DIGITS    = 3;

  localparam logic [7:0] BYTE_LF   = 8'h0A;
  localparam logic [7:0] BYTE_DASH = 8'h2D;
  localparam logic [7:0] BYTE_ZERO = 8'h30;
  localparam logic [7:0] BYTE_NINE = 8'h39;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_BAD_DIGIT = 3'd1,
    ST_MISMATCH  = 3'd2,
    ST_TOO_LONG  = 3'd3,
    ST_CLOSED    = 3'd4
  } status_t;

  // One result word as held in the queue.
  typedef struct packed {
    logic [CODE_W-1:0] reply_code;
    status_t           status;
  } result_t;

  // Write side of the result queue, front to back.
  typedef struct packed {
    logic    push;
    result_t res;
  } queue_wr_t;

endpackage

@@ hdl/smtp_rcp_in_if.sv @@
// Input channel: received bytes and the link-closed flag.
interface smtp_rcp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       link_closed;

  modport source (output valid, output rx_byte, output link_closed, input ready);
  modport sink (input valid, input rx_byte, input link_closed, output ready);
endinterface

@@ hdl/smtp_rcp_out_if.sv @@
// Output channel: reply codes and status.
interface smtp_rcp_out_if;
  import smtp_rcp_pkg::*;
  logic                valid;
  logic                ready;
  logic [CODE_W-1:0]   reply_code;
  logic [STATUS_W-1:0] status;

  modport source (output valid, output reply_code, output status, input ready);
  modport sink (input valid, input reply_code, input status, output ready);
endinterface

@@ hdl/smtp_reply_code_parser_core.sv @@
// Top level of the SMTP reply-code parser.
// Takes one received byte per cycle and emits, per byte, at most one word: the
// three-digit reply code when a reply's last line ends, or an error status
// (bad digit, code mismatch, line too long, link closed) at the byte that shows
// it. Bytes are accepted back to back at one per cycle unless the stream channel
// stalls; the front parser writes each result word into a two-entry result queue
// that drives the reply channel, and the stream channel stalls only while that
// queue is full because the reply channel is not taking words.
// A line is rejected once it reaches MAX_LINE_BYTES (4096) bytes without an LF.
module smtp_reply_code_parser_core (
  input  logic           clk,
  input  logic           rst,
  smtp_rcp_in_if.sink    stream,
  smtp_rcp_out_if.source reply
);
  import smtp_rcp_pkg::*;

  queue_wr_t wr;
  logic      space;

  // Classify bytes and update line state.
  smtp_rcp_front u_front (
    .clk    (clk),
    .rst    (rst),
    .stream (stream),
    .space  (space),
    .wr     (wr)
  );

  // Queue results and drive the reply channel.
  smtp_rcp_back u_back (
    .clk   (clk),
    .rst   (rst),
    .wr    (wr),
    .space (space),
    .reply (reply)
  );

endmodule

@@ hdl/smtp_rcp_front.sv @@
// Front part: accepts bytes, tracks line and reply state, classifies results.
module smtp_rcp_front (
  input  logic                    clk,
  input  logic                    rst,
  smtp_rcp_in_if.sink             stream,
  input  logic                    space,
  output smtp_rcp_pkg::queue_wr_t wr
);
  import smtp_rcp_pkg::*;
  `include "smtp_reply_code_parser_core_assert.svh"

  logic [LB_W-1:0]   line_bytes, line_bytes_next;
  logic [CODE_W-1:0] line_code, line_code_next;
  logic [CODE_W-1:0] first_code, first_code_next;
  logic              reply_open, reply_open_next;
  logic              continues, continues_next;
  logic              skipping_line, skipping_line_next;

  logic              acc;
  logic              is_lf;
  logic              is_digit;
  logic [3:0]        digit;
  logic [13:0]       code_acc;
  logic [CODE_W-1:0] code_new;
  logic [LB_W:0]     lb_inc;
  logic              in_code;

  assign stream.ready = space;
  assign acc          = stream.valid && stream.ready;

  // Decode the byte.
  assign is_lf    = (stream.rx_byte == BYTE_LF);
  assign is_digit = (stream.rx_byte >= BYTE_ZERO) && (stream.rx_byte <= BYTE_NINE);
  assign digit    = 4'(stream.rx_byte - BYTE_ZERO);
  assign code_acc = ({4'b0, line_code} << 3) + ({4'b0, line_code} << 1) + 14'(digit);
  assign code_new = (line_bytes == '0) ? CODE_W'(digit) : code_acc[CODE_W-1:0];
  assign lb_inc   = {1'b0, line_bytes} + (LB_W+1)'(1);
  assign in_code  = (line_bytes < LB_W'(CODE_DIGITS));

  // Compute next state and the result of the accepted byte.
  always_comb begin
    line_bytes_next    = line_bytes;
    line_code_next     = line_code;
    first_code_next    = first_code;
    reply_open_next    = reply_open;
    continues_next     = continues;
    skipping_line_next = skipping_line;
    wr                 = '0;
    wr.res.status      = ST_OK;
    if (acc) begin
      if (stream.link_closed) begin
        line_bytes_next    = '0;
        line_code_next     = '0;
        first_code_next    = '0;
        reply_open_next    = 1'b0;
        continues_next     = 1'b0;
        skipping_line_next = 1'b0;
        wr.push            = 1'b1;
        wr.res.status      = ST_CLOSED;
      end else if (skipping_line) begin
        if (is_lf) begin
          skipping_line_next = 1'b0;
          line_bytes_next    = '0;
        end
      end else if (is_lf) begin
        line_bytes_next = '0;
        continues_next  = 1'b0;
        if (in_code) begin
          line_code_next  = '0;
          reply_open_next = 1'b0;
          wr.push         = 1'b1;
          wr.res.status   = ST_BAD_DIGIT;
        end else if (!continues) begin
          reply_open_next   = 1'b0;
          wr.push           = 1'b1;
          wr.res.reply_code = first_code;
        end
      end else if (in_code && !is_digit) begin
        line_bytes_next    = '0;
        line_code_next     = '0;
        reply_open_next    = 1'b0;
        continues_next     = 1'b0;
        skipping_line_next = 1'b1;
        wr.push            = 1'b1;
        wr.res.status      = ST_BAD_DIGIT;
      end else if (line_bytes == LB_W'(CODE_DIGITS - 1) && reply_open &&
                   code_new != first_code) begin
        line_bytes_next    = '0;
        line_code_next     = '0;
        reply_open_next    = 1'b0;
        continues_next     = 1'b0;
        skipping_line_next = 1'b1;
        wr.push            = 1'b1;
        wr.res.status      = ST_MISMATCH;
      end else begin
        // Accumulate the code digits and note the fourth character.
        if (in_code) begin
          line_code_next = code_new;
          if (line_bytes == LB_W'(CODE_DIGITS - 1)) begin
            first_code_next = code_new;
            reply_open_next = 1'b1;
            continues_next  = 1'b0;
          end
        end else if (line_bytes == LB_W'(CODE_DIGITS)) begin
          continues_next = (stream.rx_byte == BYTE_DASH);
        end
        // Advance the line count; drop the line when it runs too long.
        if (lb_inc >= (LB_W+1)'(MAX_LINE_BYTES)) begin
          line_bytes_next    = '0;
          line_code_next     = '0;
          reply_open_next    = 1'b0;
          continues_next     = 1'b0;
          skipping_line_next = 1'b1;
          wr.push            = 1'b1;
          wr.res.status      = ST_TOO_LONG;
        end else begin
          line_bytes_next = lb_inc[LB_W-1:0];
        end
      end
    end
  end

  // Hold the parser state.
  always_ff @(posedge clk) begin
    if (rst) begin
      line_bytes    <= '0;
      line_code     <= '0;
      first_code    <= '0;
      reply_open    <= 1'b0;
      continues     <= 1'b0;
      skipping_line <= 1'b0;
    end else begin
      line_bytes    <= line_bytes_next;
      line_code     <= line_code_next;
      first_code    <= first_code_next;
      reply_open    <= reply_open_next;
      continues     <= continues_next;
      skipping_line <= skipping_line_next;
    end
  end

  `SRCP_ASSERT(a_push_has_space, clk, rst, !wr.push || space, "result pushed into a full queue")
  `SRCP_ASSERT_NEXT(a_closed_clears, clk, rst, acc && stream.link_closed,
    line_bytes == '0 && !reply_open && !skipping_line && first_code == '0,
    "link close did not clear state")
  `SRCP_ASSERT(a_skip_not_open, clk, rst, !skipping_line || (!reply_open && !continues),
    "reply left open while skipping a line")
  `SRCP_ASSERT_NEXT(a_ok_after_lf, clk, rst, wr.push && wr.res.status == ST_OK,
    line_bytes == '0 && !reply_open, "ok result without closing the reply")

endmodule

@@ hdl/smtp_rcp_back.sv @@
// Back part: two-entry result queue that drives the reply channel.
module smtp_rcp_back (
  input  logic                    clk,
  input  logic                    rst,
  input  smtp_rcp_pkg::queue_wr_t wr,
  output logic                    space,
  smtp_rcp_out_if.source          reply
);
  import smtp_rcp_pkg::*;
  `include "smtp_reply_code_parser_core_assert.svh"

  result_t    entries [2];
  logic       rd_ptr;
  logic       wr_ptr;
  logic [1:0] count, count_next;
  logic       pop;

  assign space       = (count != 2'd2);
  assign pop         = reply.valid && reply.ready;
  assign reply.valid = (count != 2'd0);
  assign reply.reply_code = entries[rd_ptr].reply_code;
  assign reply.status     = entries[rd_ptr].status;

  // Track the fill level.
  always_comb begin
    count_next = count;
    case ({wr.push, pop})
      2'b10:   count_next = count + 2'd1;
      2'b01:   count_next = count - 2'd1;
      default: count_next = count;
    endcase
  end

  // Advance pointers and count.
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      count <= count_next;
      if (wr.push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
    end
  end

  // Store pushed words.
  always_ff @(posedge clk) begin
    if (wr.push) entries[wr_ptr] <= wr.res;
  end

  `SRCP_ASSERT(a_count_range, clk, rst, count <= 2'd2, "queue count out of range")
  `SRCP_ASSERT(a_ptr_match, clk, rst, (count == 2'd1) == (rd_ptr != wr_ptr),
    "queue pointers disagree with count")
  `SRCP_ASSERT_NEXT(a_full_holds, clk, rst, count == 2'd2 && !pop, count == 2'd2,
    "full queue lost a word without a pop")

endmodule
